### hw/rtl/ssr_pkg.sv
// Shared constants, types and sequencer states of the subset-sum reachability block.
package ssr_pkg;

  localparam int MAX_TARGET  = 1023;
  localparam int WEIGHT_W    = 10;
  localparam int TARGET_W    = 10;
  localparam int WORD_W      = 32;
  localparam int SHIFT_W     = $clog2(WORD_W);
  localparam int STORE_DEPTH = MAX_TARGET + 1;
  localparam int NUM_WORDS   = (STORE_DEPTH + WORD_W - 1) / WORD_W;
  localparam int IDX_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SRC_W       = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_RUN,
    ST_DRAIN,
    ST_FETCH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              rd_a_en;
    logic [IDX_W-1:0]  rd_a_addr;
    logic              rd_b_en;
    logic [IDX_W-1:0]  rd_b_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              clear;
  } store_req_t;

endpackage

### hw/rtl/ssr_if.sv
// Request channel interfaces for weights, results and target configuration.
interface ssr_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssr_pkg::WEIGHT_W-1:0]  item_weight;
  logic                          last_item;
  modport source (output valid, output item_weight, output last_item, input ready);
  modport sink   (input valid, input item_weight, input last_item, output ready);
endinterface

interface ssr_out_if;
  logic valid;
  logic ready;
  logic target_reachable;
  modport source (output valid, output target_reachable, input ready);
  modport sink   (input valid, input target_reachable, output ready);
endinterface

interface ssr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ssr_pkg::TARGET_W-1:0]  target_sum;
  modport source (output valid, output target_sum, input ready);
  modport sink   (input valid, input target_sum, output ready);
endinterface

### hw/rtl/ssr_store.sv
// Reachable-sum store: word memory with two registered read ports and per-word valid bits.
module ssr_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssr_pkg::store_req_t            req,
  output logic [ssr_pkg::WORD_W-1:0]     rd_a_data,
  output logic [ssr_pkg::WORD_W-1:0]     rd_b_data
);

  logic [ssr_pkg::WORD_W-1:0]    mem [ssr_pkg::NUM_WORDS];
  logic [ssr_pkg::NUM_WORDS-1:0] valid_r;
  logic [ssr_pkg::WORD_W-1:0]    a_raw_r;
  logic [ssr_pkg::WORD_W-1:0]    b_raw_r;
  logic                          a_ok_r;
  logic                          b_ok_r;
  logic                          a_zero_r;
  logic                          b_zero_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_a_en) begin
      a_raw_r  <= mem[req.rd_a_addr];
      a_ok_r   <= valid_r[req.rd_a_addr];
      a_zero_r <= (req.rd_a_addr == '0);
    end
    if (req.rd_b_en) begin
      b_raw_r  <= mem[req.rd_b_addr];
      b_ok_r   <= valid_r[req.rd_b_addr];
      b_zero_r <= (req.rd_b_addr == '0);
    end
  end

  // An unwritten word reads as its reset value: only sum zero reachable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_a_data = a_ok_r ? a_raw_r
                   : (a_zero_r ? ssr_pkg::WORD_W'(1) : '0);
  assign rd_b_data = b_ok_r ? b_raw_r
                   : (b_zero_r ? ssr_pkg::WORD_W'(1) : '0);

endmodule

### hw/rtl/subset_sum_reachability_top.sv
// Top level of the subset-sum reachability block: sequencer, word shifter and result register.
// Weights arrive one per request; the last one of a set is flagged, and after it one result
// tells whether the configured target sum is reachable by some subset. Reachable sums sit in a
// memory of 32-bit words, and each weight w is applied by one shared funnel shifter that ORs the
// store, shifted up by w, into itself one word per cycle, walking down from the top word. After
// accepting a weight the block does a priming read, an update of each destination word from
// the top down to word floor(w/32) and a drain step before it is ready again; a weight of zero
// or above the largest tracked sum skips these steps. For the flagged item the block then reads
// the target word and, once the result register is free, loads the target bit into it; the
// register then waits for the sink while new weights are taken. The store returns to only sum zero
// reachable at once when the result is loaded, so no clearing pass is needed. The target is
// written through the configuration channel, which is always ready.
module subset_sum_reachability_top (
  input  logic          clk,
  input  logic          rst_n,
  ssr_in_if.sink        in_chan,
  ssr_out_if.source     out_chan,
  ssr_cfg_if.sink       cfg_chan
);

  localparam int W  = ssr_pkg::WORD_W;
  localparam int IW = ssr_pkg::IDX_W;
  localparam int SW = ssr_pkg::SRC_W;
  localparam int HW = ssr_pkg::SHIFT_W;

  ssr_pkg::state_t     state_r, state_nxt;
  ssr_pkg::store_req_t req;

  logic [IW-1:0]                 q_r, q_nxt;
  logic [HW-1:0]                 r_r, r_nxt;
  logic                          last_r, last_nxt;
  logic [IW-1:0]                 dst_r, dst_nxt;
  logic [SW-1:0]                 src_r, src_nxt;
  logic [IW-1:0]                 wdst_r, wdst_nxt;
  logic                          a_pend_r, a_pend_nxt;
  logic                          b_pend_r, b_pend_nxt;
  logic                          b_neg_r, b_neg_nxt;
  logic [W-1:0]                  hold_r, hold_nxt;
  logic [ssr_pkg::TARGET_W-1:0]  target_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_reach_r, out_reach_nxt;

  logic [W-1:0]    rd_a_data;
  logic [W-1:0]    rd_b_data;
  logic [W-1:0]    lo_word;
  logic [2*W-1:0]  fun_cat;
  logic [2*W-1:0]  fun_shift;
  logic [HW:0]     shamt;
  logic [IW-1:0]   top_src;
  logic            skip_weight;

  ssr_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // Shared unit: upper word of {hi, lo} shifted left by the weight's bit offset.
  assign lo_word   = b_neg_r ? '0 : rd_b_data;
  assign fun_cat   = {hold_r, lo_word};
  assign shamt     = (HW + 1)'(W) - {1'b0, r_r};
  assign fun_shift = fun_cat >> shamt;
  assign top_src   = IW'(ssr_pkg::NUM_WORDS - 1) - q_r;

  assign skip_weight = (in_chan.item_weight == '0)
                    || (32'(in_chan.item_weight) > ssr_pkg::MAX_TARGET);

  assign in_chan.ready  = (state_r == ssr_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.target_reachable = out_reach_r;

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    last_nxt      = last_r;
    dst_nxt       = dst_r;
    src_nxt       = src_r;
    wdst_nxt      = wdst_r;
    a_pend_nxt    = 1'b0;
    b_pend_nxt    = 1'b0;
    b_neg_nxt     = b_neg_r;
    hold_nxt      = b_pend_r ? lo_word : hold_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_reach_nxt = out_reach_r;
    req           = '0;

    // Retire the word read in the previous step.
    req.wr_en   = a_pend_r;
    req.wr_addr = wdst_r;
    req.wr_data = rd_a_data | fun_shift[W-1:0];

    case (state_r)
      ssr_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          q_nxt    = IW'(in_chan.item_weight >> HW);
          r_nxt    = in_chan.item_weight[HW-1:0];
          last_nxt = in_chan.last_item;
          if (skip_weight) begin
            state_nxt = in_chan.last_item ? ssr_pkg::ST_FETCH : ssr_pkg::ST_IDLE;
          end else begin
            state_nxt = ssr_pkg::ST_PRIME;
          end
        end
      end
      ssr_pkg::ST_PRIME: begin
        req.rd_b_en   = 1'b1;
        req.rd_b_addr = top_src;
        b_pend_nxt    = 1'b1;
        b_neg_nxt     = 1'b0;
        dst_nxt       = IW'(ssr_pkg::NUM_WORDS - 1);
        src_nxt       = {1'b0, top_src} - SW'(1);
        state_nxt     = ssr_pkg::ST_RUN;
      end
      ssr_pkg::ST_RUN: begin
        req.rd_a_en   = 1'b1;
        req.rd_a_addr = dst_r;
        req.rd_b_en   = !src_r[SW-1];
        req.rd_b_addr = src_r[IW-1:0];
        a_pend_nxt    = 1'b1;
        b_pend_nxt    = 1'b1;
        b_neg_nxt     = src_r[SW-1];
        wdst_nxt      = dst_r;
        if (dst_r == q_r) begin
          state_nxt = ssr_pkg::ST_DRAIN;
        end else begin
          dst_nxt = dst_r - IW'(1);
          src_nxt = src_r - SW'(1);
        end
      end
      ssr_pkg::ST_DRAIN: begin
        state_nxt = last_r ? ssr_pkg::ST_FETCH : ssr_pkg::ST_IDLE;
      end
      ssr_pkg::ST_FETCH: begin
        req.rd_a_en   = 1'b1;
        req.rd_a_addr = IW'(target_r >> HW);
        state_nxt     = ssr_pkg::ST_RESULT;
      end
      ssr_pkg::ST_RESULT: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_reach_nxt = (32'(target_r) > ssr_pkg::MAX_TARGET) ? 1'b0
                        : rd_a_data[target_r[HW-1:0]];
          req.clear     = 1'b1;
          state_nxt     = ssr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssr_pkg::ST_IDLE;
      a_pend_r    <= 1'b0;
      b_pend_r    <= 1'b0;
      b_neg_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_pend_r    <= a_pend_nxt;
      b_pend_r    <= b_pend_nxt;
      b_neg_r     <= b_neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    r_r         <= r_nxt;
    last_r      <= last_nxt;
    dst_r       <= dst_nxt;
    src_r       <= src_nxt;
    wdst_r      <= wdst_nxt;
    hold_r      <= hold_nxt;
    out_reach_r <= out_reach_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_chan.valid) begin
      target_r <= cfg_chan.target_sum;
    end
  end

  a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    a_pend_r |-> (state_r == ssr_pkg::ST_RUN || state_r == ssr_pkg::ST_DRAIN))
    else $error("store write outside a weight update");

  a_dst_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssr_pkg::ST_RUN) |-> (dst_r >= q_r))
    else $error("destination word below the weight's word offset");

  a_wdst_floor: assert property (@(posedge clk) disable iff (!rst_n)
    a_pend_r |-> (wdst_r >= q_r))
    else $error("write to a word the weight cannot change");

  a_clear_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    req.clear |=> (out_valid_r && state_r == ssr_pkg::ST_IDLE))
    else $error("store cleared without loading a result");

  a_prime_then_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssr_pkg::ST_PRIME) |=> (state_r == ssr_pkg::ST_RUN && b_pend_r && !a_pend_r))
    else $error("priming read not followed by the update walk");

endmodule

### tb/subset_sum_reachability_top_test.sv
// Self-checking testbench of the subset-sum reachability block with random flow control.
`timescale 1ns / 1ps

module subset_sum_reachability_top_test;

  localparam int IDLE_SETTLE = 48;    // longest weight plus target fetch, with margin
  localparam int STALL_LIMIT = 5000;  // cycles without any request before giving up
  localparam int LONG_HOLD   = 400;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;
  typedef enum int {WS_FULL, WS_SMALL, WS_SPLIT, WS_EDGE} weight_style_t;

  typedef struct packed {
    logic target_reachable;
  } reach_result_t;

  logic clk;
  logic rst_n;

  ssr_in_if  in_chan ();
  ssr_out_if out_chan ();
  ssr_cfg_if cfg_chan ();

  subset_sum_reachability_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predictor state
  logic [ssr_pkg::STORE_DEPTH-1:0] reach_map;
  logic [ssr_pkg::TARGET_W-1:0]    target_reg;
  reach_result_t                   pending_results[$];

  int mismatches;
  int weights_taken;
  int results_checked;
  int results_reachable;
  int target_writes;
  int quiet_cycles;

  logic [ssr_pkg::TARGET_W-1:0] cur_target;
  bit gaps_enabled;
  int burst_left;
  bit hold_results_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [ssr_pkg::STORE_DEPTH-1:0] add_weight(
      input logic [ssr_pkg::STORE_DEPTH-1:0] sums,
      input logic [ssr_pkg::WEIGHT_W-1:0] w);
    if (w == 0 || w > ssr_pkg::MAX_TARGET) return sums;
    return sums | (sums << w);
  endfunction

  function automatic logic [ssr_pkg::STORE_DEPTH-1:0] empty_map();
    logic [ssr_pkg::STORE_DEPTH-1:0] m;
    m = '0;
    m[0] = 1'b1;
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Predict on every accepted request, check every accepted result.
  initial begin
    reach_map  = empty_map();
    target_reg = '0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((cfg_chan.valid && cfg_chan.ready) || (in_chan.valid && in_chan.ready) ||
            (out_chan.valid && out_chan.ready))
          quiet_cycles = 0;
        else
          quiet_cycles++;
        if (cfg_chan.valid && cfg_chan.ready) target_reg = cfg_chan.target_sum;
        if (out_chan.valid && out_chan.ready) begin
          if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0b with none expected",
                                      out_chan.target_reachable));
          end else begin
            reach_result_t exp_res;
            exp_res = pending_results.pop_front();
            if (out_chan.target_reachable !== exp_res.target_reachable)
              report_mismatch($sformatf("target_reachable got %b expected %b",
                                        out_chan.target_reachable, exp_res.target_reachable));
            results_checked++;
            if (exp_res.target_reachable) results_reachable++;
          end
        end
        if (in_chan.valid && in_chan.ready) begin
          weights_taken++;
          reach_map = add_weight(reach_map, in_chan.item_weight);
          if (in_chan.last_item) begin
            reach_result_t res;
            res.target_reachable = (target_reg > ssr_pkg::MAX_TARGET) ? 1'b0
                                 : reach_map[target_reg];
            pending_results.push_back(res);
            reach_map = empty_map();
          end
        end
      end
    end
  end

  // Result side: own stall pattern, plus a long hold-off on request.
  initial begin
    rx_mode_t mode;
    int mode_left;
    int tick;
    mode = RX_OPEN;
    mode_left = 0;
    tick = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results_req) begin
        out_chan.ready <= 1'b0;
        for (int k = 1; k < LONG_HOLD; k++) begin
          @(negedge clk);
          out_chan.ready <= 1'b0;
        end
        hold_results_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:     out_chan.ready <= 1'b1;
          RX_COIN:     out_chan.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY:   out_chan.ready <= ($urandom_range(0, 9) != 0);
          default:     out_chan.ready <= ((tick % 11) < 6);
        endcase
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic hold_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_chan.valid       <= 1'b0;
      in_chan.item_weight <= ssr_pkg::WEIGHT_W'($urandom);
      in_chan.last_item   <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic send_weight(input logic [ssr_pkg::WEIGHT_W-1:0] w, input logic last);
    @(negedge clk);
    in_chan.valid       <= 1'b1;
    in_chan.item_weight <= w;
    in_chan.last_item   <= last;
    do @(posedge clk); while (!in_chan.ready);
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        hold_sender($urandom_range(1, 15));
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_drained();
    hold_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Unflagged weights leave nothing to wait for, so let the last one finish too.
  task automatic wait_block_idle();
    wait_results_drained();
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_target(input logic [ssr_pkg::TARGET_W-1:0] t);
    wait_block_idle();
    @(negedge clk);
    cfg_chan.valid      <= 1'b1;
    cfg_chan.target_sum <= t;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid      <= 1'b0;
    cur_target = t;
    target_writes++;
  endtask

  function automatic logic [ssr_pkg::TARGET_W-1:0] choose_target();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ssr_pkg::TARGET_W'(ssr_pkg::MAX_TARGET);
      2:       return ssr_pkg::TARGET_W'(1);
      3:       return ssr_pkg::TARGET_W'($urandom_range(2, 63));
      default: return ssr_pkg::TARGET_W'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int len);
    weight_style_t style;
    int rem;
    int w;
    style = weight_style_t'($urandom_range(0, 3));
    rem = int'(cur_target);
    for (int i = 0; i < len; i++) begin
      case (style)
        WS_FULL:  w = int'($urandom_range(0, 1023));
        WS_SMALL: w = int'($urandom_range(0, cur_target / len + 3));
        WS_SPLIT: begin
          // weights that add up to the target, sometimes knocked off by one
          w = (i == len - 1) ? rem : int'($urandom_range(0, rem));
          rem -= w;
          if (i == len - 1 && $urandom_range(0, 3) == 0) w++;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       w = 0;
            1:       w = 1;
            2:       w = ssr_pkg::MAX_TARGET;
            3:       w = 512;
            4:       w = int'(cur_target);
            default: w = ssr_pkg::MAX_TARGET - 1;
          endcase
        end
      endcase
      if (w > ssr_pkg::MAX_TARGET) w = ssr_pkg::MAX_TARGET;
      send_weight(ssr_pkg::WEIGHT_W'(w), i == len - 1);
    end
  endtask

  task automatic test_reset_target_zero();
    send_weight(10'd0, 1'b1);
    send_weight(10'd1023, 1'b1);
    send_weight(10'd5, 1'b0);
    send_weight(10'd7, 1'b1);
  endtask

  task automatic test_target_extremes();
    write_target(ssr_pkg::TARGET_W'(ssr_pkg::MAX_TARGET));
    send_weight(10'd1023, 1'b1);
    send_weight(10'd512, 1'b0);
    send_weight(10'd511, 1'b1);
    send_weight(10'd0, 1'b1);
    send_weight(10'd1022, 1'b0);
    send_weight(10'd0, 1'b0);
    send_weight(10'd1, 1'b1);
    write_target(ssr_pkg::TARGET_W'(1));
    send_weight(10'd1, 1'b1);
    send_weight(10'd2, 1'b0);
    send_weight(10'd1023, 1'b1);
    write_target(ssr_pkg::TARGET_W'(682));
    send_weight(10'd341, 1'b0);
    send_weight(10'd341, 1'b1);
  endtask

  task automatic test_midset_target_rewrite();
    write_target(ssr_pkg::TARGET_W'(5));
    send_weight(10'd2, 1'b0);
    send_weight(10'd3, 1'b0);
    write_target(ssr_pkg::TARGET_W'(7));
    send_weight(10'd4, 1'b1);
    write_target(ssr_pkg::TARGET_W'(1000));
    send_weight(10'd600, 1'b0);
    send_weight(10'd700, 1'b0);
    send_weight(10'd300, 1'b1);
  endtask

  // Hold results back long enough that the block must stall its input.
  task automatic test_result_backpressure();
    write_target(ssr_pkg::TARGET_W'(40));
    gaps_enabled = 1'b0;
    hold_results_req = 1'b1;
    for (int s = 0; s < 12; s++) send_random_set(2);
    gaps_enabled = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_pause_until_drained();
    write_target(choose_target());
    for (int s = 0; s < 6; s++) begin
      send_random_set($urandom_range(1, 4));
      wait_results_drained();
    end
  endtask

  task automatic test_random_sets(input int n_items);
    int sent;
    int phase_left;
    int len;
    sent = 0;
    phase_left = 0;
    while (sent < n_items) begin
      if (phase_left <= 0) begin
        write_target(choose_target());
        gaps_enabled = ($urandom_range(0, 3) != 0);
        phase_left = $urandom_range(80, 160);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      send_random_set(len);
      sent += len;
      phase_left -= len;
      if ($urandom_range(0, 14) == 0) wait_results_drained();
    end
  endtask

  initial begin
    mismatches = 0;
    weights_taken = 0;
    results_checked = 0;
    results_reachable = 0;
    target_writes = 0;
    quiet_cycles = 0;
    cur_target = '0;
    gaps_enabled = 1'b1;
    burst_left = 0;
    hold_results_req = 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.item_weight <= '0;
    in_chan.last_item   <= 1'b0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.target_sum <= '0;
    @(posedge rst_n);
    @(posedge clk);

    test_reset_target_zero();
    test_target_extremes();
    test_midset_target_rewrite();
    test_result_backpressure();
    test_pause_until_drained();
    test_random_sets(1400);

    wait_block_idle();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Covered %0d weights and %0d results (%0d reachable) over %0d target settings",
             weights_taken, results_checked, results_reachable, target_writes);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
